### sv/mwf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, codes and constants of the right-hand wall follower.
// No dependencies; used by every other file of the block except mwf_ram.
package mwf_pkg;

    // Grid geometry
    localparam int GRID_DIM = 16;
    localparam int CELL_W   = 4;                          // row / column field width
    localparam int ADDR_W   = $clog2(GRID_DIM * GRID_DIM);
    localparam int DEPTH    = GRID_DIM * GRID_DIM;
    localparam int USED_W   = 5;                          // rows_used / cols_used width
    localparam int LIM_MAX  = (GRID_DIM < 16) ? GRID_DIM : 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_USED     = 3'd0,
        CFG_COLS_USED     = 3'd1,
        CFG_START_ROW     = 3'd2,
        CFG_START_COL     = 3'd3,
        CFG_START_HEADING = 3'd4
    } t_cfg_idx;

    // Request operations
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_RESTART = 2'd1;
    localparam logic [1:0] OP_MOVE    = 2'd2;

    // Cell kinds
    localparam logic [1:0] KIND_OPEN  = 2'd0;
    localparam logic [1:0] KIND_WALL  = 2'd1;
    localparam logic [1:0] KIND_EXIT  = 2'd2;
    localparam logic [1:0] KIND_START = 2'd3;

    // Headings
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // Walk status
    localparam logic [1:0] ST_WALKING = 2'd0;
    localparam logic [1:0] ST_EXIT    = 2'd1;
    localparam logic [1:0] ST_START   = 2'd2;

    // Reset values
    localparam logic [USED_W-1:0] RST_ROWS_USED     = 5'd12;
    localparam logic [USED_W-1:0] RST_COLS_USED     = 5'd12;
    localparam logic [CELL_W-1:0] RST_START_ROW     = 4'd3;
    localparam logic [CELL_W-1:0] RST_START_COL     = 4'd10;
    localparam logic [1:0]        RST_START_HEADING = DIR_UP;

    typedef struct packed {
        logic [1:0]        op;
        logic [CELL_W-1:0] cell_row;
        logic [CELL_W-1:0] cell_col;
        logic [1:0]        cell_kind;
    } t_req;

    typedef struct packed {
        logic [CELL_W-1:0] pos_row;
        logic [CELL_W-1:0] pos_col;
        logic [1:0]        heading;
        logic [1:0]        walk_status;
    } t_rsp;

    // Clamp a rows/columns-in-use value to the grid
    function automatic logic [USED_W-1:0] limit_of(input logic [USED_W-1:0] used);
        logic [USED_W-1:0] lim;
        lim = USED_W'(LIM_MAX);
        return (used > lim) ? lim : used;
    endfunction

    // Flat memory address of a cell
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CELL_W-1:0] r,
                                                    input logic [CELL_W-1:0] c);
        return ADDR_W'(32'(r) * GRID_DIM + 32'(c));
    endfunction

endpackage
`default_nettype wire

### sv/mwf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-port RAM with registered read data.
// No dependencies.
module mwf_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### sv/maze_wall_follower_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Right-hand wall follower: grid memory, walker state and move sequencer.
// Depends on mwf_pkg and mwf_ram.
//
// Usage:
//   Requests enter on i_in_valid / o_in_ready with an mwf_pkg::t_req payload:
//   write one grid cell, restart the walker at the configured start, or make
//   one move. Every request yields exactly one response on o_out_valid /
//   i_out_ready carrying the walker position, heading and walk status.
//   Configuration (rows/cols in use, start cell, start heading) is written
//   through i_cfg_we / i_cfg_idx / i_cfg_data while no request is in flight.
//
// Sequencing:
//   A write, restart or halted move goes from acceptance to S_DONE, which loads
//   the response register. A move probes neighbours right, forward, left, back
//   through the single grid memory port: an in-range neighbour is read in S_PROBE
//   and checked in S_CHECK, an out-of-range one is passed over in S_PROBE. One
//   request is worked on at a time.
//
// Reset and stalls:
//   Reset (i_rst_n low, synchronous) restores the configuration defaults,
//   places the walker at the default start cell and status walking. Grid
//   contents are not cleared; cells must be written before a move reads them.
//   The response sits in an output register, so a new request is accepted
//   while a finished response still waits; the sequencer holds in its final
//   state only if a second response is ready before the first is taken.
module maze_wall_follower_step (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire mwf_pkg::t_req                    i_in_req,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output mwf_pkg::t_rsp                         o_out_rsp,
    input  wire logic                             i_cfg_we,
    input  wire logic [mwf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mwf_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_CHECK = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // Configuration registers
    logic [mwf_pkg::USED_W-1:0] r_rows_used;
    logic [mwf_pkg::USED_W-1:0] r_cols_used;
    logic [mwf_pkg::CELL_W-1:0] r_start_row;
    logic [mwf_pkg::CELL_W-1:0] r_start_col;
    logic [1:0]                 r_start_heading;

    // Walker state
    logic [mwf_pkg::CELL_W-1:0] r_row, n_row;
    logic [mwf_pkg::CELL_W-1:0] r_col, n_col;
    logic [1:0]                 r_head, n_head;
    logic [1:0]                 r_status, n_status;

    // Sequencer
    t_state                     r_state, n_state;
    logic [1:0]                 r_try, n_try;
    logic [mwf_pkg::CELL_W-1:0] r_cand_row, n_cand_row;
    logic [mwf_pkg::CELL_W-1:0] r_cand_col, n_cand_col;
    logic [1:0]                 r_cand_head, n_cand_head;

    // Output register
    logic          r_out_valid, n_out_valid;
    mwf_pkg::t_rsp r_out_rsp, n_out_rsp;

    // Memory port
    logic                       ram_we;
    logic [mwf_pkg::ADDR_W-1:0] ram_addr;
    logic [1:0]                 ram_rdata;

    // Neighbour of the current cell in the probed direction
    logic [1:0]                 probe_head;
    logic [mwf_pkg::USED_W-1:0] nb_row5, nb_col5;
    logic                       nb_ok;
    logic                       in_acc;
    logic                       out_free;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Try order right, forward, left, back: heading offset is try ^ 1
    assign probe_head = r_head + (r_try ^ 2'b01);

    always_comb begin
        nb_row5 = {1'b0, r_row};
        nb_col5 = {1'b0, r_col};
        nb_ok   = 1'b1;
        case (probe_head)
            mwf_pkg::DIR_UP: begin
                if (r_row == '0) nb_ok = 1'b0;
                nb_row5 = nb_row5 - 1'b1;
            end
            mwf_pkg::DIR_RIGHT: nb_col5 = nb_col5 + 1'b1;
            mwf_pkg::DIR_DOWN:  nb_row5 = nb_row5 + 1'b1;
            mwf_pkg::DIR_LEFT: begin
                if (r_col == '0) nb_ok = 1'b0;
                nb_col5 = nb_col5 - 1'b1;
            end
            default: nb_ok = 1'b0;
        endcase
        // Cells beyond the rows and columns in use are walls
        if (nb_row5 >= mwf_pkg::limit_of(r_rows_used) ||
            nb_col5 >= mwf_pkg::limit_of(r_cols_used)) begin
            nb_ok = 1'b0;
        end
    end

    // Memory: cell writes happen at request acceptance, probe reads in S_PROBE
    assign ram_we = in_acc && (i_in_req.op == mwf_pkg::OP_WRITE) &&
                    (32'(i_in_req.cell_row) < mwf_pkg::GRID_DIM) &&
                    (32'(i_in_req.cell_col) < mwf_pkg::GRID_DIM);
    assign ram_addr = ram_we ? mwf_pkg::cell_addr(i_in_req.cell_row, i_in_req.cell_col)
                             : mwf_pkg::cell_addr(nb_row5[mwf_pkg::CELL_W-1:0],
                                                  nb_col5[mwf_pkg::CELL_W-1:0]);

    mwf_ram #(
        .WIDTH (2),
        .DEPTH (mwf_pkg::DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_in_req.cell_kind),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_try       = r_try;
        n_row       = r_row;
        n_col       = r_col;
        n_head      = r_head;
        n_status    = r_status;
        n_cand_row  = r_cand_row;
        n_cand_col  = r_cand_col;
        n_cand_head = r_cand_head;
        n_out_valid = r_out_valid;
        n_out_rsp   = r_out_rsp;

        // Drop the response once taken
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_try   = '0;
                    n_state = S_DONE;
                    case (i_in_req.op)
                        mwf_pkg::OP_RESTART: begin
                            n_row    = r_start_row;
                            n_col    = r_start_col;
                            n_head   = r_start_heading;
                            n_status = mwf_pkg::ST_WALKING;
                        end
                        mwf_pkg::OP_MOVE: begin
                            // A halted walk stays put
                            if (r_status == mwf_pkg::ST_WALKING) n_state = S_PROBE;
                        end
                        default: ;
                    endcase
                end
            end
            S_PROBE: begin
                if (nb_ok) begin
                    // Read issued this cycle; check the cell next cycle
                    n_cand_row  = nb_row5[mwf_pkg::CELL_W-1:0];
                    n_cand_col  = nb_col5[mwf_pkg::CELL_W-1:0];
                    n_cand_head = probe_head;
                    n_state     = S_CHECK;
                end else if (r_try == 2'd3) begin
                    n_state = S_DONE;
                end else begin
                    n_try = r_try + 1'b1;
                end
            end
            S_CHECK: begin
                if (ram_rdata != mwf_pkg::KIND_WALL) begin
                    n_row  = r_cand_row;
                    n_col  = r_cand_col;
                    n_head = r_cand_head;
                    if (ram_rdata == mwf_pkg::KIND_EXIT) begin
                        n_status = mwf_pkg::ST_EXIT;
                    end else if (ram_rdata == mwf_pkg::KIND_START) begin
                        n_status = mwf_pkg::ST_START;
                    end
                    n_state = S_DONE;
                end else if (r_try == 2'd3) begin
                    // Boxed in on all sides: stay with heading unchanged
                    n_state = S_DONE;
                end else begin
                    n_try   = r_try + 1'b1;
                    n_state = S_PROBE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_rsp.pos_row     = r_row;
                    n_out_rsp.pos_col     = r_col;
                    n_out_rsp.heading     = r_head;
                    n_out_rsp.walk_status = r_status;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_try           <= '0;
            r_row           <= mwf_pkg::RST_START_ROW;
            r_col           <= mwf_pkg::RST_START_COL;
            r_head          <= mwf_pkg::RST_START_HEADING;
            r_status        <= mwf_pkg::ST_WALKING;
            r_out_valid     <= 1'b0;
            r_rows_used     <= mwf_pkg::RST_ROWS_USED;
            r_cols_used     <= mwf_pkg::RST_COLS_USED;
            r_start_row     <= mwf_pkg::RST_START_ROW;
            r_start_col     <= mwf_pkg::RST_START_COL;
            r_start_heading <= mwf_pkg::RST_START_HEADING;
        end else begin
            r_state     <= n_state;
            r_try       <= n_try;
            r_row       <= n_row;
            r_col       <= n_col;
            r_head      <= n_head;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mwf_pkg::CFG_ROWS_USED:     r_rows_used <= i_cfg_data;
                    mwf_pkg::CFG_COLS_USED:     r_cols_used <= i_cfg_data;
                    mwf_pkg::CFG_START_ROW:
                        r_start_row <= i_cfg_data[mwf_pkg::CELL_W-1:0];
                    mwf_pkg::CFG_START_COL:
                        r_start_col <= i_cfg_data[mwf_pkg::CELL_W-1:0];
                    mwf_pkg::CFG_START_HEADING: r_start_heading <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cand_row  <= n_cand_row;
        r_cand_col  <= n_cand_col;
        r_cand_head <= n_cand_head;
        r_out_rsp   <= n_out_rsp;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule
`default_nettype wire

### sv/mwf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checker for the wall follower, bound to the top level.
// Depends on mwf_pkg and maze_wall_follower_step.
module mwf_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire mwf_pkg::t_rsp o_out_rsp
);

    // One request in flight: no acceptance in the cycle after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted back to back");

    // A new response is only loaded while the request side is closed
    a_rsp_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> !$past(o_in_ready))
        else $error("response appeared without work in progress");

    // Status codes stay within walking, exit and start marker
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_rsp.walk_status == mwf_pkg::ST_WALKING ||
                         o_out_rsp.walk_status == mwf_pkg::ST_EXIT ||
                         o_out_rsp.walk_status == mwf_pkg::ST_START))
        else $error("illegal walk status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("response dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_rsp))
        else $error("response changed while stalled");

endmodule

bind maze_wall_follower_step mwf_checker u_mwf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_rsp   (o_out_rsp)
);
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for maze_wall_follower_step: random maze requests with a cycle-free
// walker predictor, random handshake idling and a per-field response scoreboard.
// Depends on mwf_pkg and the maze_wall_follower_step RTL.
module tb_top;

    // Unused request code: the block reports its state and changes nothing
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Quiet cycles (nothing accepted on either side) before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // Stimulus stops growing once this many requests are queued
    localparam int REQUEST_TARGET = 750;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Request side
    logic          in_valid = 1'b0;
    logic          in_ready;
    mwf_pkg::t_req in_req   = '0;

    // Response side
    logic          out_valid;
    logic          out_ready = 1'b0;
    mwf_pkg::t_rsp out_rsp;

    // Configuration port
    logic [mwf_pkg::CFG_IDX_W-1:0]  cfg_idx  = mwf_pkg::CFG_ROWS_USED;
    logic [mwf_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           cfg_we   = 1'b0;

    // Requests waiting for the driver, and walker states waiting for their response
    mwf_pkg::t_req pending_req_q[$];
    mwf_pkg::t_rsp expected_walker_q[$];

    int send_wait    = 0;
    int recv_wait    = 0;
    int recv_draw;
    int quiet_cycles = 0;
    int mismatch_cnt = 0;
    int queued_cnt   = 0;
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    mwf_pkg::t_rsp want_rsp;

    // Predicted block state: configuration copy, walker and maze contents
    logic [mwf_pkg::USED_W-1:0] cfg_rows_used = mwf_pkg::RST_ROWS_USED;
    logic [mwf_pkg::USED_W-1:0] cfg_cols_used = mwf_pkg::RST_COLS_USED;
    logic [mwf_pkg::CELL_W-1:0] cfg_start_row = mwf_pkg::RST_START_ROW;
    logic [mwf_pkg::CELL_W-1:0] cfg_start_col = mwf_pkg::RST_START_COL;
    logic [1:0]                 cfg_start_hd  = mwf_pkg::RST_START_HEADING;
    logic [mwf_pkg::CELL_W-1:0] walker_row    = mwf_pkg::RST_START_ROW;
    logic [mwf_pkg::CELL_W-1:0] walker_col    = mwf_pkg::RST_START_COL;
    logic [1:0]                 walker_hd     = mwf_pkg::RST_START_HEADING;
    logic [1:0]                 walker_status = mwf_pkg::ST_WALKING;
    logic [1:0]                 maze_cell [mwf_pkg::DEPTH];

    maze_wall_follower_step i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_rsp   (out_rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Apply one request to the predicted state and return the walker state it leaves.
    function automatic mwf_pkg::t_rsp next_walker_state(input mwf_pkg::t_req req);
        mwf_pkg::t_rsp rsp;
        logic [1:0]    probe_hd;
        logic          stepped;
        int            row_lim;
        int            col_lim;
        int            nr;
        int            nc;
        int            k;
        row_lim = (cfg_rows_used > mwf_pkg::LIM_MAX) ? mwf_pkg::LIM_MAX
                                                     : int'(cfg_rows_used);
        col_lim = (cfg_cols_used > mwf_pkg::LIM_MAX) ? mwf_pkg::LIM_MAX
                                                     : int'(cfg_cols_used);
        stepped = 1'b0;
        case (req.op)
            mwf_pkg::OP_WRITE: begin
                maze_cell[int'(req.cell_row) * mwf_pkg::GRID_DIM + int'(req.cell_col)] =
                    req.cell_kind;
            end
            mwf_pkg::OP_RESTART: begin
                // The start cell itself is not looked at
                walker_row    = cfg_start_row;
                walker_col    = cfg_start_col;
                walker_hd     = cfg_start_hd;
                walker_status = mwf_pkg::ST_WALKING;
            end
            mwf_pkg::OP_MOVE: begin
                // A halted walk ignores moves until the next restart
                if (walker_status == mwf_pkg::ST_WALKING) begin
                    // Probe right, straight, left, back: heading offsets 1, 0, 3, 2
                    for (k = 0; k < 4 && !stepped; k++) begin
                        probe_hd = walker_hd + 2'(5 - k);
                        nr = walker_row;
                        nc = walker_col;
                        case (probe_hd)
                            mwf_pkg::DIR_UP:    nr = nr - 1;
                            mwf_pkg::DIR_RIGHT: nc = nc + 1;
                            mwf_pkg::DIR_DOWN:  nr = nr + 1;
                            default:            nc = nc - 1;
                        endcase
                        // Anything outside the rows and columns in use is a wall
                        if (nr >= 0 && nc >= 0 && nr < row_lim && nc < col_lim &&
                            maze_cell[nr * mwf_pkg::GRID_DIM + nc] != mwf_pkg::KIND_WALL) begin
                            walker_row = 4'(nr);
                            walker_col = 4'(nc);
                            walker_hd  = probe_hd;
                            if (maze_cell[nr * mwf_pkg::GRID_DIM + nc] == mwf_pkg::KIND_EXIT)
                                walker_status = mwf_pkg::ST_EXIT;
                            else if (maze_cell[nr * mwf_pkg::GRID_DIM + nc] ==
                                     mwf_pkg::KIND_START)
                                walker_status = mwf_pkg::ST_START;
                            stepped = 1'b1;
                        end
                    end
                    // Boxed in on all four sides: stay put, heading unchanged
                end
            end
            default: begin
            end
        endcase
        rsp.pos_row     = walker_row;
        rsp.pos_col     = walker_col;
        rsp.heading     = walker_hd;
        rsp.walk_status = walker_status;
        return rsp;
    endfunction

    function automatic int draw_wait(input bit idle_on);
        return idle_on ? int'($urandom_range(0, 14)) : 0;
    endfunction

    // Cell kind with the given percentages of walls and of each marker kind
    function automatic logic [1:0] draw_kind(input int wall_pct, input int marker_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < marker_pct)                return mwf_pkg::KIND_EXIT;
        if (pick < 2 * marker_pct)            return mwf_pkg::KIND_START;
        if (pick < 2 * marker_pct + wall_pct) return mwf_pkg::KIND_WALL;
        return mwf_pkg::KIND_OPEN;
    endfunction

    function automatic logic [mwf_pkg::USED_W-1:0] draw_used();
        if ($urandom_range(0, 3) == 0)
            return ($urandom_range(0, 1) == 0) ? mwf_pkg::USED_W'(1)
                                               : mwf_pkg::USED_W'(mwf_pkg::LIM_MAX);
        return mwf_pkg::USED_W'($urandom_range(1, mwf_pkg::LIM_MAX));
    endfunction

    task automatic queue_request(input logic [1:0] op,
                                 input logic [mwf_pkg::CELL_W-1:0] row,
                                 input logic [mwf_pkg::CELL_W-1:0] col,
                                 input logic [1:0] kind);
        mwf_pkg::t_req req;
        req.op        = op;
        req.cell_row  = row;
        req.cell_col  = col;
        req.cell_kind = kind;
        pending_req_q.push_back(req);
        queued_cnt++;
    endtask

    // Hold until every queued request went out and every response came back.
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_req_q.size() != 0 || in_valid || expected_walker_q.size() != 0);
    endtask

    // Write all five registers while the block is idle, then mirror them in the predictor.
    task automatic load_walk_config(input logic [mwf_pkg::USED_W-1:0] rows,
                                    input logic [mwf_pkg::USED_W-1:0] cols,
                                    input logic [mwf_pkg::CELL_W-1:0] srow,
                                    input logic [mwf_pkg::CELL_W-1:0] scol,
                                    input logic [1:0]                 shd);
        wait_drained();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= mwf_pkg::CFG_ROWS_USED;
        cfg_data <= rows;
        @(posedge clk);
        cfg_idx  <= mwf_pkg::CFG_COLS_USED;
        cfg_data <= cols;
        @(posedge clk);
        cfg_idx  <= mwf_pkg::CFG_START_ROW;
        cfg_data <= mwf_pkg::CFG_DATA_W'(srow);
        @(posedge clk);
        cfg_idx  <= mwf_pkg::CFG_START_COL;
        cfg_data <= mwf_pkg::CFG_DATA_W'(scol);
        @(posedge clk);
        cfg_idx  <= mwf_pkg::CFG_START_HEADING;
        cfg_data <= mwf_pkg::CFG_DATA_W'(shd);
        @(posedge clk);
        cfg_we   <= 1'b0;
        cfg_rows_used = rows;
        cfg_cols_used = cols;
        cfg_start_row = srow;
        cfg_start_col = scol;
        cfg_start_hd  = shd;
        @(negedge clk);
    endtask

    // One walk: new configuration, an optional start-marker write, restart, then a random mix led by moves.
    task automatic run_walk_phase(input logic [mwf_pkg::USED_W-1:0] rows,
                                  input logic [mwf_pkg::USED_W-1:0] cols,
                                  input logic [mwf_pkg::CELL_W-1:0] srow,
                                  input logic [mwf_pkg::CELL_W-1:0] scol,
                                  input logic [1:0]                 shd);
        int         n_req;
        int         pick;
        logic [1:0] op;
        load_walk_config(rows, cols, srow, scol, shd);
        send_idle_on = ($urandom_range(0, 3) != 0);
        recv_idle_on = ($urandom_range(0, 3) != 0);
        // Sometimes mark the start cell so a walk that comes home halts there
        if ($urandom_range(0, 2) == 0)
            queue_request(mwf_pkg::OP_WRITE, srow, scol, mwf_pkg::KIND_START);
        queue_request(mwf_pkg::OP_RESTART, 4'($urandom), 4'($urandom), 2'($urandom));
        n_req = $urandom_range(20, 70);
        repeat (n_req) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      op = mwf_pkg::OP_MOVE;
            else if (pick < 84) op = mwf_pkg::OP_WRITE;
            else if (pick < 95) op = mwf_pkg::OP_RESTART;
            else                op = OP_UNUSED;
            queue_request(op, 4'($urandom), 4'($urandom),
                          (op == mwf_pkg::OP_WRITE) ? draw_kind(40, 5) : 2'($urandom));
        end
    endtask

    // Driver: present one request at a time, predict it on acceptance, then idle a while.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            send_wait <= 0;
        end else begin
            if (in_valid && in_ready)
                expected_walker_q.push_back(next_walker_state(in_req));
            if (!in_valid || in_ready) begin
                if (send_wait > 0) begin
                    send_wait <= send_wait - 1;
                    in_valid  <= 1'b0;
                end else if (pending_req_q.size() > 0) begin
                    in_req    <= pending_req_q.pop_front();
                    in_valid  <= 1'b1;
                    send_wait <= draw_wait(send_idle_on);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted response with the oldest prediction, then stall a while.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end else if (out_valid && out_ready) begin
            if (expected_walker_q.size() == 0) begin
                $error("response with no request pending: row %0d col %0d heading %0d status %0d",
                       out_rsp.pos_row, out_rsp.pos_col, out_rsp.heading, out_rsp.walk_status);
                mismatch_cnt++;
            end else begin
                want_rsp = expected_walker_q.pop_front();
                if (out_rsp.pos_row !== want_rsp.pos_row) begin
                    $error("pos_row: expected %0d, actual %0d", want_rsp.pos_row, out_rsp.pos_row);
                    mismatch_cnt++;
                end
                if (out_rsp.pos_col !== want_rsp.pos_col) begin
                    $error("pos_col: expected %0d, actual %0d", want_rsp.pos_col, out_rsp.pos_col);
                    mismatch_cnt++;
                end
                if (out_rsp.heading !== want_rsp.heading) begin
                    $error("heading: expected %0d, actual %0d", want_rsp.heading, out_rsp.heading);
                    mismatch_cnt++;
                end
                if (out_rsp.walk_status !== want_rsp.walk_status) begin
                    $error("walk_status: expected %0d, actual %0d",
                           want_rsp.walk_status, out_rsp.walk_status);
                    mismatch_cnt++;
                end
            end
            recv_draw = draw_wait(recv_idle_on);
            recv_wait <= recv_draw;
            out_ready <= (recv_draw == 0);
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            out_ready <= (recv_wait == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog: drop the run if neither side moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int phase_idx;
        int r;
        int c;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, reset configuration: unused op with all-ones fields, restart, and
        // writes at the field extremes. No move yet, so no cell is read.
        queue_request(OP_UNUSED, 4'd15, 4'd15, mwf_pkg::KIND_START);
        queue_request(mwf_pkg::OP_RESTART, 4'd0, 4'd0, mwf_pkg::KIND_OPEN);
        queue_request(mwf_pkg::OP_WRITE, 4'd15, 4'd15, mwf_pkg::KIND_WALL);
        queue_request(mwf_pkg::OP_WRITE, 4'd0, 4'd0, mwf_pkg::KIND_OPEN);

        // Directed, one row by two columns starting top-left heading up: only cells
        // (0,0) and (0,1) are ever in reach.
        load_walk_config(5'd1, 5'd2, 4'd0, 4'd0, mwf_pkg::DIR_UP);
        queue_request(mwf_pkg::OP_WRITE, 4'd0, 4'd0, mwf_pkg::KIND_OPEN);
        queue_request(mwf_pkg::OP_WRITE, 4'd0, 4'd1, mwf_pkg::KIND_EXIT);
        queue_request(mwf_pkg::OP_WRITE, 4'd1, 4'd0, mwf_pkg::KIND_WALL);
        queue_request(mwf_pkg::OP_RESTART, 4'd0, 4'd0, mwf_pkg::KIND_OPEN);
        // right turn onto the exit
        queue_request(mwf_pkg::OP_MOVE, 4'd0, 4'd0, mwf_pkg::KIND_OPEN);
        // halted: nothing changes
        queue_request(mwf_pkg::OP_MOVE, 4'd15, 4'd15, mwf_pkg::KIND_WALL);
        queue_request(mwf_pkg::OP_RESTART, 4'd0, 4'd0, mwf_pkg::KIND_OPEN);
        queue_request(mwf_pkg::OP_WRITE, 4'd0, 4'd1, mwf_pkg::KIND_START);
        // back on a start marker
        queue_request(mwf_pkg::OP_MOVE, 4'd0, 4'd0, mwf_pkg::KIND_OPEN);
        queue_request(mwf_pkg::OP_RESTART, 4'd0, 4'd0, mwf_pkg::KIND_OPEN);
        queue_request(mwf_pkg::OP_WRITE, 4'd0, 4'd1, mwf_pkg::KIND_WALL);
        // boxed in: stay put
        queue_request(mwf_pkg::OP_MOVE, 4'd0, 4'd0, mwf_pkg::KIND_OPEN);
        queue_request(mwf_pkg::OP_WRITE, 4'd0, 4'd1, mwf_pkg::KIND_OPEN);
        // step right, then dead end: turn back
        queue_request(mwf_pkg::OP_MOVE, 4'd0, 4'd0, mwf_pkg::KIND_OPEN);
        queue_request(mwf_pkg::OP_MOVE, 4'd0, 4'd0, mwf_pkg::KIND_OPEN);

        // Fill the whole grid so later walks never read an unwritten cell
        for (r = 0; r < mwf_pkg::GRID_DIM; r++)
            for (c = 0; c < mwf_pkg::GRID_DIM; c++)
                queue_request(mwf_pkg::OP_WRITE, 4'(r), 4'(c), draw_kind(34, 3));

        // Walks: the configuration corners first, then random settings
        phase_idx = 0;
        while (queued_cnt < REQUEST_TARGET) begin
            case (phase_idx)
                0: run_walk_phase(5'd16, 5'd16, 4'd15, 4'd15, mwf_pkg::DIR_LEFT);
                1: run_walk_phase(5'd1, 5'd1, 4'd0, 4'd0, mwf_pkg::DIR_UP);
                2: run_walk_phase(5'd16, 5'd1, 4'd15, 4'd0, mwf_pkg::DIR_DOWN);
                3: run_walk_phase(5'd1, 5'd16, 4'd0, 4'd15, mwf_pkg::DIR_RIGHT);
                default: run_walk_phase(draw_used(), draw_used(), 4'($urandom),
                                        4'($urandom), 2'($urandom));
            endcase
            phase_idx++;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0 && expected_walker_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
